>>> hdl/fr_pkg.sv
// fr_pkg: widths, state encoding and controller/datapath interface types
// shared by every module of the fraction reducer
// depends on nothing
`timescale 1ns / 1ps

package fr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
    localparam int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EUC_CHECK,
        ST_EUC_WAIT,
        ST_DIVN_WAIT,
        ST_DIVD_START,
        ST_DIVD_WAIT,
        ST_FINISH
    } fr_state_t;

    typedef enum logic [1:0] {
        DIV_EUCLID,
        DIV_NUM,
        DIV_DEN
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     euclid_step;
        logic     store_qn;
        logic     store_qd;
        logic     load_out;
    } fr_cmd_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic div_done;
    } fr_status_t;

endpackage

>>> hdl/fr_divider.sv
// fr_divider: unsigned restoring divider, one quotient bit per cycle
// uses fr_pkg for the data width
`timescale 1ns / 1ps

module fr_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fr_pkg::DATA_WIDTH-1:0]  dividend,
    input  logic [fr_pkg::DATA_WIDTH-1:0]  divisor,
    output logic                           done,
    output logic [fr_pkg::DATA_WIDTH-1:0]  quotient,
    output logic [fr_pkg::DATA_WIDTH-1:0]  remainder
);

    localparam int DW = fr_pkg::DATA_WIDTH;

    logic [DW-1:0]             rem_reg, rem_next;
    logic [DW-1:0]             quo_reg, quo_next;
    logic [DW-1:0]             dvs_reg, dvs_next;
    logic [fr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [DW:0]               shifted;
    logic [DW:0]               trial;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = fr_pkg::CNT_W'(DW);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DW])
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fr_pkg::CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/fr_datapath.sv
// fr_datapath: operand registers, euclid and quotient registers, output register
// uses fr_pkg and the shared fr_divider
`timescale 1ns / 1ps

module fr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fr_pkg::fr_cmd_t                cmd,
    output fr_pkg::fr_status_t             status,
    input  logic [fr_pkg::DATA_WIDTH-1:0]  num_in,
    input  logic [fr_pkg::DATA_WIDTH-1:0]  den_in,
    output logic [fr_pkg::DATA_WIDTH-1:0]  num_out,
    output logic [fr_pkg::DATA_WIDTH-1:0]  den_out,
    output logic                           zero_error
);

    localparam int DW = fr_pkg::DATA_WIDTH;

    logic [DW-1:0] n_reg, d_reg, a_reg, b_reg, qn_reg, qd_reg;
    logic [DW-1:0] num_out_reg, den_out_reg;
    logic          zero_error_reg;
    logic [DW-1:0] mag_num_in, mag_den_in, mag_n, mag_d;
    logic [DW-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic          div_done;

    assign mag_num_in = num_in[DW-1] ? DW'(-num_in) : num_in;
    assign mag_den_in = den_in[DW-1] ? DW'(-den_in) : den_in;
    assign mag_n      = n_reg[DW-1] ? DW'(-n_reg) : n_reg;
    assign mag_d      = d_reg[DW-1] ? DW'(-d_reg) : d_reg;

    always_comb
    begin
        unique case (cmd.div_sel)
            fr_pkg::DIV_EUCLID:
            begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
            fr_pkg::DIV_NUM:
            begin
                div_dividend = mag_n;
                div_divisor  = a_reg;
            end
            fr_pkg::DIV_DEN:
            begin
                div_dividend = mag_d;
                div_divisor  = a_reg;
            end
            default:
            begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
        endcase
    end

    fr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            n_reg <= num_in;
            d_reg <= den_in;
            if (mag_num_in < mag_den_in)
            begin
                a_reg <= mag_den_in;
                b_reg <= mag_num_in;
            end
            else
            begin
                a_reg <= mag_num_in;
                b_reg <= mag_den_in;
            end
        end
        else if (cmd.euclid_step)
        begin
            a_reg <= b_reg;
            b_reg <= div_rem;
        end
        if (cmd.store_qn)
        begin
            qn_reg <= n_reg[DW-1] ? DW'(-div_quo) : div_quo;
        end
        if (cmd.store_qd)
        begin
            qd_reg <= d_reg[DW-1] ? DW'(-div_quo) : div_quo;
        end
        if (cmd.load_out)
        begin
            num_out_reg    <= (a_reg == '0) ? n_reg : qn_reg;
            den_out_reg    <= (a_reg == '0) ? d_reg : qd_reg;
            zero_error_reg <= (a_reg == '0);
        end
    end

    assign status.a_zero   = (a_reg == '0);
    assign status.b_zero   = (b_reg == '0);
    assign status.div_done = div_done;

    assign num_out    = num_out_reg;
    assign den_out    = den_out_reg;
    assign zero_error = zero_error_reg;

endmodule

>>> hdl/fr_controller.sv
// fr_controller: sequencer for euclid steps, the two divisions and output hand-off
// uses fr_pkg for states and command/status types
`timescale 1ns / 1ps

module fr_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  fr_pkg::fr_status_t status,
    output fr_pkg::fr_cmd_t    cmd
);

    fr_pkg::fr_state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fr_pkg::ST_EUC_CHECK;
                end
            end
            fr_pkg::ST_EUC_CHECK:
            begin
                if (!status.b_zero)
                begin
                    state_next = fr_pkg::ST_EUC_WAIT;
                end
                else if (status.a_zero)
                begin
                    state_next = fr_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = fr_pkg::ST_DIVN_WAIT;
                end
            end
            fr_pkg::ST_EUC_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = fr_pkg::ST_EUC_CHECK;
                end
            end
            fr_pkg::ST_DIVN_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = fr_pkg::ST_DIVD_START;
                end
            end
            fr_pkg::ST_DIVD_START:
            begin
                state_next = fr_pkg::ST_DIVD_WAIT;
            end
            fr_pkg::ST_DIVD_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = fr_pkg::ST_FINISH;
                end
            end
            fr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = fr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fr_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        cmd.div_sel = fr_pkg::DIV_EUCLID;
        in_ready = 1'b0;
        unique case (state_reg)
            fr_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            fr_pkg::ST_EUC_CHECK:
            begin
                cmd.div_start = !(status.b_zero && status.a_zero);
                cmd.div_sel   = status.b_zero ? fr_pkg::DIV_NUM : fr_pkg::DIV_EUCLID;
            end
            fr_pkg::ST_EUC_WAIT:
            begin
                cmd.euclid_step = status.div_done;
            end
            fr_pkg::ST_DIVN_WAIT:
            begin
                cmd.store_qn = status.div_done;
            end
            fr_pkg::ST_DIVD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fr_pkg::DIV_DEN;
            end
            fr_pkg::ST_DIVD_WAIT:
            begin
                cmd.store_qd = status.div_done;
            end
            fr_pkg::ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/fraction_reducer.sv
// fraction_reducer: top level, reduces num/den by their gcd (euclid, then two divisions)
// instantiates fr_controller and fr_datapath, uses fr_pkg
//
// channel   dir  transfer when                  contents
// s_axis    in   s_axis_tvalid & s_axis_tready  tdata: num_in, den_in
// m_axis    out  m_axis_tvalid & m_axis_tready  tdata: num_out, den_out; tuser: zero_error
//
// one item at a time on a single shared restoring divider, one quotient bit per cycle
// the result waits in an output register, so the next item is taken while it is unread
// rst_n clears the sequencer and output valid; no memory to clear
`timescale 1ns / 1ps

module fraction_reducer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [fr_pkg::TDATA_W-1:0]  s_axis_tdata,   // num_in, den_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [fr_pkg::TDATA_W-1:0]  m_axis_tdata,   // num_out, den_out
    output logic                        m_axis_tuser    // zero_error
);

    localparam int DW = fr_pkg::DATA_WIDTH;

    fr_pkg::fr_cmd_t    cmd;
    fr_pkg::fr_status_t status;
    logic [DW-1:0]      num_out, den_out;
    logic               zero_error;

    fr_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    fr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .num_in     (s_axis_tdata[DW-1:0]),
        .den_in     (s_axis_tdata[2*DW-1:DW]),
        .num_out    (num_out),
        .den_out    (den_out),
        .zero_error (zero_error)
    );

    assign m_axis_tdata = fr_pkg::TDATA_W'({den_out, num_out});
    assign m_axis_tuser = zero_error;

endmodule

>>> tb/tb_fraction_reducer.sv
// tb_fraction_reducer: stream testbench for the gcd-based fraction reducer, with directed
// corner cases, shaped random operands, receiver hold-off and an in-bench predictor
// depends on fr_pkg and fraction_reducer
`timescale 1ns / 1ps

module tb_fraction_reducer;

    localparam int DW          = fr_pkg::DATA_WIDTH;
    localparam int HOLD_CYCLES = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2000;

    typedef logic [DW-1:0] word_t;

    typedef struct {
        word_t num;
        word_t den;
        logic  zero_err;
    } reduced_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [fr_pkg::TDATA_W-1:0] s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [fr_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                       m_axis_tuser;

    reduced_t pending_fracs[$];
    int       src_idle_pct;
    int       snk_idle_pct;
    bit       hold_req;
    int       hold_left;
    int       err_count;
    int       sent_count;
    int       checked_count;
    int       zero_err_count;
    int       stall_cycles;

    fraction_reducer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic word_t abs_val(input word_t v);
        if (v[DW-1])
            return word_t'(0) - v;
        return v;
    endfunction

    function automatic word_t trunc_div(input word_t v, input word_t g);
        word_t q;
        q = abs_val(v) / g;
        if (v[DW-1])
            q = word_t'(0) - q;
        return q;
    endfunction

    function automatic reduced_t reduce_fraction(input word_t n, input word_t d);
        reduced_t res;
        word_t    a;
        word_t    b;
        word_t    r;
        a = abs_val(n);
        b = abs_val(d);
        if (a < b)
        begin
            r = a;
            a = b;
            b = r;
        end
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        if (a == 0)
        begin
            res.num      = n;
            res.den      = d;
            res.zero_err = 1'b1;
        end
        else
        begin
            res.num      = trunc_div(n, a);
            res.den      = trunc_div(d, a);
            res.zero_err = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_frac(input word_t n, input word_t d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= fr_pkg::TDATA_W'({d, n});
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_fracs.push_back(reduce_fraction(n, d));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_fracs.size() != 0)
            @(negedge clk);
    endtask

    function automatic word_t apply_sign(input word_t v);
        if ($urandom_range(1))
            return word_t'(0) - v;
        return v;
    endfunction

    function automatic word_t any_operand();
        word_t v;
        v = $urandom;
        if (v == {1'b1, {(DW-1){1'b0}}})
            v = {1'b1, {(DW-2){1'b0}}, 1'b1};
        return v;
    endfunction

    task automatic test_directed();
        word_t max_pos;
        word_t max_neg;
        max_pos = {1'b0, {(DW-1){1'b1}}};
        max_neg = word_t'(0) - max_pos;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_frac(0, 0);
        send_frac(0, 5);
        send_frac(5, 0);
        send_frac(0, word_t'(-5));
        send_frac(word_t'(-7), 0);
        send_frac(max_pos, max_pos);
        send_frac(max_neg, max_pos);
        send_frac(max_pos, max_neg);
        send_frac(max_neg, max_neg);
        send_frac(max_pos, 1);
        send_frac(1, max_pos);
        send_frac(max_neg, word_t'(-1));
        send_frac(6, 4);
        send_frac(word_t'(-6), 4);
        send_frac(6, word_t'(-4));
        send_frac(word_t'(-6), word_t'(-4));
        send_frac(4, 6);
        send_frac(1836311903, 1134903170);
        send_frac(word_t'(-1134903170), 1836311903);
        send_frac(2147483629, 2147483587);
        send_frac(32'h7fff_0000, 32'h0001_0000);
        send_frac(12345, 12345);
        send_frac(1, 1);
        send_frac(32'h5555_5555, 32'h2aaa_aaaa);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random(input int count, input int src_pct, input int snk_pct);
        word_t n;
        word_t d;
        word_t g;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    n = any_operand();
                    d = any_operand();
                end
                4, 5, 6:
                begin
                    g = $urandom_range(65535, 1);
                    n = apply_sign(word_t'($urandom_range(30000, 1)) * g);
                    d = apply_sign(word_t'($urandom_range(30000, 1)) * g);
                end
                7:
                begin
                    n = apply_sign($urandom_range(100));
                    d = apply_sign($urandom_range(100));
                end
                8:
                begin
                    n = $urandom_range(1) ? any_operand() : 0;
                    d = (n == 0 && $urandom_range(1)) ? any_operand() : 0;
                end
                default:
                begin
                    n = any_operand();
                    d = $urandom_range(1) ? n : word_t'(0) - n;
                end
            endcase
            send_frac(n, d);
        end
        stop_sending();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
        for (int i = 0; i < 10; i++)
            send_frac(any_operand(), word_t'($urandom_range(1000, 1)) * 3);
        stop_sending();
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        reduced_t want;
        word_t    got_num;
        word_t    got_den;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_num = m_axis_tdata[DW-1:0];
            got_den = m_axis_tdata[2*DW-1:DW];
            if (pending_fracs.size() == 0)
                report_mismatch("result with nothing pending", got_num, got_den);
            else
            begin
                want = pending_fracs.pop_front();
                checked_count++;
                if (want.zero_err)
                    zero_err_count++;
                if (got_num !== want.num)
                    report_mismatch("num_out", got_num, want.num);
                if (got_den !== want.den)
                    report_mismatch("den_out", got_den, want.den);
                if (m_axis_tuser !== want.zero_err)
                    report_mismatch("zero_error", word_t'(m_axis_tuser), word_t'(want.zero_err));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        err_count      = 0;
        sent_count     = 0;
        checked_count  = 0;
        zero_err_count = 0;
        stall_cycles   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(330, 28, 84);
        wait_drained();
        test_random(330, 84, 28);
        test_backpressure();
        test_random(340, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("covered %0d fractions: zero pairs, one-sided zeros, sign mixes, extremes,",
                 sent_count);
        $display("common factors and random idling/hold-off; %0d results checked, %0d flagged",
                 checked_count, zero_err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
hdl/fr_pkg.sv
hdl/fr_divider.sv
hdl/fr_datapath.sv
hdl/fr_controller.sv
hdl/fraction_reducer.sv
tb/tb_fraction_reducer.sv
